// ===== sv/tbp_pkg.sv =====
// Shared types, codes and constants of the tagged branch predictor.
package tbp_pkg;

    // Fixed field widths of the request and result words.
    localparam int ADDR_BITS = 48;
    localparam int CNT_W     = 32;
    localparam int USEFUL_W  = 3;
    localparam int PROV_W    = 3;

    // Action codes carried in the request word.
    localparam logic [1:0] ACT_PREDICT = 2'd0;
    localparam logic [1:0] ACT_UPDATE  = 2'd1;
    localparam logic [1:0] ACT_PREFILL = 2'd2;

    // Hash geometry: index and tag windows step by four bits per table.
    localparam int          IDX_SHIFT     = 2;
    localparam int          TAG_SHIFT     = 6;
    localparam int          HASH_STRIDE   = 4;
    localparam logic [63:0] HASH_LOW_MASK = 64'hFFF;

    // Useful counter limits and the fall-through address step.
    localparam logic [USEFUL_W-1:0]  USEFUL_MAX     = 3'd7;
    localparam logic [USEFUL_W-1:0]  USEFUL_PREFILL = 3'd2;
    localparam logic [ADDR_BITS-1:0] PC_STEP        = 48'd4;

    typedef struct packed {
        logic [1:0]           action;
        logic [ADDR_BITS-1:0] branch_address;
        logic                 resolved_taken;
        logic [ADDR_BITS-1:0] target_address;
        logic                 last_of_batch;
    } request_t;

    typedef struct packed {
        logic                 predicted_taken;
        logic [ADDR_BITS-1:0] predicted_target;
        logic [PROV_W-1:0]    provider_table;
        logic [CNT_W-1:0]     prediction_count;
        logic [CNT_W-1:0]     correct_count;
        logic [CNT_W-1:0]     mispredict_count;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic eval;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } sts_t;

endpackage

// ===== sv/tbp_ram.sv =====
// Generic single-port RAM with a registered read.
module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write at the addressed entry and register the old contents for reading.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tbp_ctrl.sv =====
// Controller state machine: clearing pass, idle and evaluate states.
module tbp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output tbp_pkg::cmd_t cmd,
    input  tbp_pkg::sts_t sts
);

    tbp_pkg::ctrl_state_t state_reg;
    tbp_pkg::ctrl_state_t state_next;
    logic                 done_reg;
    logic                 done_next;

    // State and strobe registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbp_pkg::ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done_next  = 1'b0;
        case (state_reg)
            tbp_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = tbp_pkg::ST_IDLE;
                end
            end
            tbp_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = tbp_pkg::ST_EVAL;
                end
            end
            tbp_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                done_next  = 1'b1;
                state_next = tbp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tbp_pkg::ST_CLEAR;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ===== sv/tbp_datapath.sv =====
// Datapath: tagged tables, target buffer, hashing, training and statistics.
module tbp_datapath #(
    parameter int TABLE_COUNT    = 4,
    parameter int TABLE_ENTRIES  = 4096,
    parameter int BUFFER_ENTRIES = 8192,
    parameter int TAG_BITS       = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tbp_pkg::cmd_t     cmd,
    output tbp_pkg::sts_t     sts,
    input  tbp_pkg::request_t request,
    output tbp_pkg::result_t  result
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int BUF_W  = $clog2(BUFFER_ENTRIES);
    localparam int CLR_W  = (IDX_W > BUF_W) ? IDX_W : BUF_W;
    localparam int ENT_W  = TAG_BITS + tbp_pkg::USEFUL_W + 2;
    localparam int BUF_DW = 2 * tbp_pkg::ADDR_BITS + 1;
    localparam logic [tbp_pkg::PROV_W-1:0] PROV_NONE = tbp_pkg::PROV_W'(TABLE_COUNT);

    tbp_pkg::request_t req_reg;
    tbp_pkg::result_t  result_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;
    logic [tbp_pkg::CNT_W-1:0] upd_cnt_reg, upd_cnt_next;
    logic [tbp_pkg::CNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [tbp_pkg::CNT_W-1:0] miss_cnt_reg, miss_cnt_next;
    tbp_pkg::result_t  result_next;

    logic [tbp_pkg::ADDR_BITS-1:0] addr_sel;
    logic [63:0]                   addr_wide;
    logic [63:0]                   req_wide;

    logic [IDX_W-1:0]    tbl_addr  [TABLE_COUNT];
    logic [TAG_BITS-1:0] tbl_tag   [TABLE_COUNT];
    logic [ENT_W-1:0]    tbl_rdata [TABLE_COUNT];
    logic [ENT_W-1:0]    tbl_wdata [TABLE_COUNT];
    logic [TABLE_COUNT-1:0] tbl_we;
    logic [TABLE_COUNT-1:0] tbl_hit;
    logic [TABLE_COUNT-1:0] tbl_free;

    logic [BUF_W-1:0]  buf_addr;
    logic              buf_we;
    logic [BUF_DW-1:0] buf_wdata;
    logic [BUF_DW-1:0] buf_rdata;

    logic                          any_hit;
    logic [tbp_pkg::PROV_W-1:0]    prov_num;
    logic [ENT_W-1:0]              prov_ent;
    logic [TABLE_COUNT-1:0]        prov_oh;
    logic [TABLE_COUNT-1:0]        alloc_oh;
    logic [ENT_W-1:0]              trained_ent;
    logic [tbp_pkg::USEFUL_W-1:0]  prov_useful;
    logic                          prov_taken;
    logic                          buf_hit;
    logic                          prefill_taken;
    logic                          is_update;
    logic                          is_prefill;

    // Request word is held for the evaluate cycle, in which the result word is registered.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= request;
        end
        if (cmd.eval)
        begin
            result_reg <= result_next;
        end
    end

    // Clearing counter and statistics counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            upd_cnt_reg  <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (cmd.eval)
            begin
                upd_cnt_reg  <= upd_cnt_next;
                hit_cnt_reg  <= hit_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
            end
        end
    end

    assign sts.clear_last = (clr_cnt_reg == {CLR_W{1'b1}});
    assign is_update      = (req_reg.action == tbp_pkg::ACT_UPDATE);
    assign is_prefill     = (req_reg.action == tbp_pkg::ACT_PREFILL);

    // Memories are read with the incoming address and written with the held one.
    assign addr_sel  = cmd.accept ? request.branch_address : req_reg.branch_address;
    assign addr_wide = 64'(addr_sel);
    assign req_wide  = 64'(req_reg.branch_address);

    // Per-table row index and tag hashes.
    always_comb
    begin
        for (int t = 0; t < TABLE_COUNT; t++)
        begin
            tbl_addr[t] = cmd.clear ? clr_cnt_reg[IDX_W-1:0]
                        : IDX_W'(addr_wide >> (tbp_pkg::IDX_SHIFT + tbp_pkg::HASH_STRIDE * t));
            tbl_tag[t]  = TAG_BITS'((req_wide >> (tbp_pkg::TAG_SHIFT + tbp_pkg::HASH_STRIDE * t))
                        ^ (req_wide & tbp_pkg::HASH_LOW_MASK));
        end
    end

    // Hit and free flags, provider (highest hit) and allocation (lowest free).
    always_comb
    begin
        any_hit  = 1'b0;
        prov_num = PROV_NONE;
        prov_ent = '0;
        prov_oh  = '0;
        alloc_oh = '0;
        for (int t = 0; t < TABLE_COUNT; t++)
        begin
            tbl_hit[t]  = tbl_rdata[t][ENT_W-1] && (tbl_rdata[t][ENT_W-2:4] == tbl_tag[t]);
            tbl_free[t] = !tbl_rdata[t][ENT_W-1] || (tbl_rdata[t][3:1] == '0);
            if (tbl_hit[t])
            begin
                any_hit    = 1'b1;
                prov_num   = tbp_pkg::PROV_W'(t);
                prov_ent   = tbl_rdata[t];
                prov_oh    = '0;
                prov_oh[t] = 1'b1;
            end
        end
        for (int t = TABLE_COUNT - 1; t >= 0; t--)
        begin
            if (tbl_free[t])
            begin
                alloc_oh    = '0;
                alloc_oh[t] = 1'b1;
            end
        end
    end

    // Training of the provider entry: saturating useful count, direction flip at zero.
    assign prov_useful = prov_ent[3:1];
    assign prov_taken  = prov_ent[0];
    always_comb
    begin
        trained_ent = prov_ent;
        if (prov_taken == req_reg.resolved_taken)
        begin
            if (prov_useful < tbp_pkg::USEFUL_MAX)
            begin
                trained_ent[3:1] = prov_useful + tbp_pkg::USEFUL_W'(1);
            end
        end
        else if (prov_useful != '0)
        begin
            trained_ent[3:1] = prov_useful - tbp_pkg::USEFUL_W'(1);
        end
        else
        begin
            trained_ent[0] = req_reg.resolved_taken;
        end
    end

    assign prefill_taken = (req_reg.target_address > req_reg.branch_address);

    // Table write enables and data.
    always_comb
    begin
        for (int t = 0; t < TABLE_COUNT; t++)
        begin
            tbl_we[t]    = 1'b0;
            tbl_wdata[t] = '0;
            if (cmd.clear)
            begin
                tbl_we[t] = 1'b1;
            end
            else if (cmd.eval && is_update && any_hit && prov_oh[t])
            begin
                tbl_we[t]    = 1'b1;
                tbl_wdata[t] = trained_ent;
            end
            else if (cmd.eval && is_update && !any_hit && alloc_oh[t])
            begin
                tbl_we[t]    = 1'b1;
                tbl_wdata[t] = {1'b1, tbl_tag[t], tbp_pkg::USEFUL_W'(0), req_reg.resolved_taken};
            end
            else if (cmd.eval && is_prefill)
            begin
                tbl_we[t]    = 1'b1;
                tbl_wdata[t] = {1'b1, tbl_tag[t], tbp_pkg::USEFUL_PREFILL, prefill_taken};
            end
        end
    end

    // Target buffer port.
    assign buf_addr  = cmd.clear ? clr_cnt_reg[BUF_W-1:0] : addr_sel[BUF_W-1:0];
    assign buf_we    = cmd.clear || (cmd.eval && (is_update || is_prefill));
    assign buf_wdata = cmd.clear ? '0
                     : {1'b1, req_reg.branch_address, req_reg.target_address};
    assign buf_hit   = buf_rdata[BUF_DW-1]
                     && (buf_rdata[BUF_DW-2:tbp_pkg::ADDR_BITS] == req_reg.branch_address);

    // Result word and statistics.
    always_comb
    begin
        upd_cnt_next  = upd_cnt_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        result_next   = '0;
        result_next.provider_table = PROV_NONE;
        case (req_reg.action)
            tbp_pkg::ACT_PREDICT:
            begin
                result_next.provider_table   = prov_num;
                result_next.predicted_taken  = any_hit ? prov_taken : buf_hit;
                result_next.predicted_target = buf_hit ? buf_rdata[tbp_pkg::ADDR_BITS-1:0]
                                             : req_reg.branch_address + tbp_pkg::PC_STEP;
            end
            tbp_pkg::ACT_UPDATE:
            begin
                result_next.provider_table = prov_num;
                upd_cnt_next = upd_cnt_reg + tbp_pkg::CNT_W'(1);
                if (any_hit && (prov_taken == req_reg.resolved_taken))
                begin
                    hit_cnt_next = hit_cnt_reg + tbp_pkg::CNT_W'(1);
                end
                else if (any_hit)
                begin
                    miss_cnt_next = miss_cnt_reg + tbp_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                result_next.provider_table = PROV_NONE;
            end
        endcase
        result_next.prediction_count = upd_cnt_next;
        result_next.correct_count    = hit_cnt_next;
        result_next.mispredict_count = miss_cnt_next;
    end

    assign result = result_reg;

    // One RAM per tagged table.
    for (genvar g = 0; g < TABLE_COUNT; g++)
    begin : g_table
        tbp_ram #(
            .WIDTH (ENT_W),
            .DEPTH (TABLE_ENTRIES)
        ) u_table_ram (
            .clk   (clk),
            .we    (tbl_we[g]),
            .addr  (tbl_addr[g]),
            .wdata (tbl_wdata[g]),
            .rdata (tbl_rdata[g])
        );
    end

    tbp_ram #(
        .WIDTH (BUF_DW),
        .DEPTH (BUFFER_ENTRIES)
    ) u_buffer_ram (
        .clk   (clk),
        .we    (buf_we),
        .addr  (buf_addr),
        .wdata (buf_wdata),
        .rdata (buf_rdata)
    );

endmodule

// ===== sv/tagged_branch_predictor_btb.sv =====
// Top level of the tagged branch predictor with target buffer.
//
//   Channel   Ports                  Handshake
//   request   start, busy, request   word taken when start is high and busy is low
//   result    done, result           word shown for one cycle while done is high
//
// Each word is read from the single-port table and buffer RAMs as it is accepted;
// the evaluate state writes back and registers the result, shown with done on the
// following cycle. Busy is high while a word is evaluated. After reset a clearing
// pass sweeps one row of every RAM per cycle until all rows are zero, with busy
// high. The receiver cannot stall; every accepted word yields exactly one result.
module tagged_branch_predictor_btb #(
    parameter int TABLE_COUNT    = 4,
    parameter int TABLE_ENTRIES  = 4096,
    parameter int BUFFER_ENTRIES = 8192,
    parameter int TAG_BITS       = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tbp_pkg::request_t request,
    output logic              done,
    output tbp_pkg::result_t  result
);

    tbp_pkg::cmd_t cmd;
    tbp_pkg::sts_t sts;

    // Sequencing.
    tbp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Tables, buffer and statistics.
    tbp_datapath #(
        .TABLE_COUNT    (TABLE_COUNT),
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .BUFFER_ENTRIES (BUFFER_ENTRIES),
        .TAG_BITS       (TAG_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .request (request),
        .result  (result)
    );

    // An accepted word always gives its result, with done, once it is evaluated.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after an accepted word");

    // Results never come on consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // A result is shown only as the block frees up after evaluating.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of an evaluation");

endmodule
